### hdl/mqsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_pkg: shared definitions for the multi-queue shared buffer
// Default sizes, field widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    // Default geometry of the slot store and the number of queues.
    localparam int SLOTS_DEF  = 16;
    localparam int QUEUES_DEF = 4;

    // Fixed field widths of one beat.
    localparam int DATA_W   = 32;
    localparam int QSEL_W   = 2;
    localparam int S_USER_W = 1 + QSEL_W;
    localparam int STATUS_W = 2;

    // Operation codes carried in the input tuser.
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

endpackage
`default_nettype wire

### hdl/multi_queue_shared_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several FIFO queues in one shared slot store
// Slots are chained through a link RAM; unused slots form a free list.
// Queue head and tail pointers live in a queue RAM, stored values in a data RAM.
// ----------------------------------------------------------------------------
// Results: an enqueue or a good dequeue is loaded from the execute state, an
// overflow or underflow from the lookup state; a stalled output holds either.
// Input: a new beat is taken only in the idle state, once the last result is
// loaded, set by the read, then modify, then write-back pass through the RAMs.
// Reset: a fill count stands in for the initial free-list chain and a valid
// bit per queue marks it empty, so no RAM clearing pass is needed.
module multi_queue_shared_buffer #(
    parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
    parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input beat: tdata = value_in; tuser = {queue_sel, action}
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mqsb_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value_in
    input  wire logic [mqsb_pkg::S_USER_W-1:0]   s_tuser,   // [0] action, [2:1] queue_sel
    // Result beat: tdata = value_out; tuser = status
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mqsb_pkg::DATA_W-1:0]     m_tdata,   // [31:0] value_out
    output logic      [mqsb_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);

    import mqsb_pkg::*;

    // Pointer holds a slot number or the null value SLOTS.
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(SLOTS);
    localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QCW = ($clog2(QUEUES + 1) > QSEL_W) ? $clog2(QUEUES + 1) : QSEL_W;
    localparam logic [PW-1:0]  NIL      = PW'(SLOTS);
    localparam logic [QCW-1:0] QUEUES_C = QCW'(QUEUES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic              act_reg, act_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [PW-1:0]     free_head_reg, free_head_next;
    logic [PW-1:0]     fresh_cnt_reg, fresh_cnt_next;
    logic [QUEUES-1:0] qvalid_reg, qvalid_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [PW-1:0]     slot_reg, slot_next;
    logic              link_tail_reg, link_tail_next;

    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    status_t             m_tuser_reg, m_tuser_next;
    logic                out_load;
    logic                out_free;
    logic                accept;

    logic [QCW-1:0]      qmod;
    logic [QW-1:0]       q_sel;

    // RAM ports.
    logic                link_we, link_re;
    logic [AW-1:0]       link_waddr, link_raddr;
    logic [PW-1:0]       link_wdata, link_rdata;
    logic                data_we, data_re;
    logic [AW-1:0]       data_waddr, data_raddr;
    logic [DATA_W-1:0]   data_rdata;
    logic                qram_we, qram_re;
    logic [QW-1:0]       qram_waddr, qram_raddr;
    logic [2*PW-1:0]     qram_wdata, qram_rdata;

    // Head and tail of the addressed queue as seen in the lookup state.
    logic [PW-1:0]       look_head, look_tail;
    logic                look_empty;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Queue number taken modulo QUEUES; the select is at most 3.
    always_comb begin
        qmod = QCW'(s_tuser[S_USER_W-1:1]);
        for (int i = 0; i < 3; i++) begin
            if (qmod >= QUEUES_C) begin
                qmod = qmod - QUEUES_C;
            end
        end
        q_sel = QW'(qmod);
    end

    // An unwritten queue entry reads as an empty queue.
    assign look_head  = qvalid_reg[q_reg] ? qram_rdata[PW-1:0] : NIL;
    assign look_tail  = qvalid_reg[q_reg] ? qram_rdata[2*PW-1:PW] : NIL;
    assign look_empty = (look_head == NIL) || (look_tail == NIL);

    // Sequencer: read queue and free-list link, then modify and write back.
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        q_next         = q_reg;
        val_next       = val_reg;
        free_head_next = free_head_reg;
        fresh_cnt_next = fresh_cnt_reg;
        qvalid_next    = qvalid_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        slot_next      = slot_reg;
        link_tail_next = link_tail_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        out_load       = 1'b0;

        link_we    = 1'b0;
        link_waddr = free_head_reg[AW-1:0];
        link_wdata = NIL;
        link_re    = 1'b0;
        link_raddr = free_head_reg[AW-1:0];
        data_we    = 1'b0;
        data_waddr = free_head_reg[AW-1:0];
        data_re    = 1'b0;
        data_raddr = look_head[AW-1:0];
        qram_we    = 1'b0;
        qram_waddr = q_reg;
        qram_wdata = {NIL, NIL};
        qram_re    = 1'b0;
        qram_raddr = q_sel;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next   = s_tuser[0];
                    q_next     = q_sel;
                    val_next   = s_tdata;
                    qram_re    = 1'b1;
                    link_re    = 1'b1;
                    state_next = S_LOOK;
                end
            end

            S_LOOK: begin
                if (act_reg == ACT_ENQ) begin
                    if (free_head_reg == NIL) begin
                        // No free slot: report overflow and change nothing.
                        if (out_free) begin
                            out_load     = 1'b1;
                            m_tdata_next = '0;
                            m_tuser_next = STAT_OVERFLOW;
                            state_next   = S_IDLE;
                        end
                    end else begin
                        // Pop the free-list head; untouched slots chain to the next one.
                        if (free_head_reg == fresh_cnt_reg) begin
                            free_head_next = free_head_reg + PW'(1);
                            fresh_cnt_next = fresh_cnt_reg + PW'(1);
                        end else begin
                            free_head_next = link_rdata;
                        end
                        link_we    = 1'b1;
                        link_waddr = free_head_reg[AW-1:0];
                        link_wdata = NIL;
                        data_we    = 1'b1;
                        data_waddr = free_head_reg[AW-1:0];
                        qram_we    = 1'b1;
                        qram_wdata = {free_head_reg, look_empty ? free_head_reg : look_head};
                        qvalid_next[q_reg] = 1'b1;
                        tail_next      = look_tail;
                        slot_next      = free_head_reg;
                        link_tail_next = !look_empty;
                        state_next     = S_EXEC;
                    end
                end else begin
                    if (look_head == NIL) begin
                        // Empty queue: report underflow and change nothing.
                        if (out_free) begin
                            out_load     = 1'b1;
                            m_tdata_next = '0;
                            m_tuser_next = STAT_UNDERFLOW;
                            state_next   = S_IDLE;
                        end
                    end else begin
                        link_re    = 1'b1;
                        link_raddr = look_head[AW-1:0];
                        data_re    = 1'b1;
                        data_raddr = look_head[AW-1:0];
                        head_next  = look_head;
                        tail_next  = look_tail;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                // Side effects of this state are held back until the result can go.
                if (out_free) begin
                    out_load     = 1'b1;
                    m_tuser_next = STAT_OK;
                    state_next   = S_IDLE;
                    if (act_reg == ACT_ENQ) begin
                        m_tdata_next = '0;
                        link_we      = link_tail_reg;
                        link_waddr   = tail_reg[AW-1:0];
                        link_wdata   = slot_reg;
                    end else begin
                        m_tdata_next = data_rdata;
                        qram_we      = 1'b1;
                        qram_wdata   = (link_rdata == NIL) ? {NIL, NIL} : {tail_reg, link_rdata};
                        link_we      = 1'b1;
                        link_waddr   = head_reg[AW-1:0];
                        link_wdata   = free_head_reg;
                        free_head_next = head_reg;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fresh_cnt_reg <= '0;
            qvalid_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fresh_cnt_reg <= fresh_cnt_next;
            qvalid_reg    <= qvalid_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        q_reg         <= q_next;
        val_reg       <= val_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        slot_reg      <= slot_next;
        link_tail_reg <= link_tail_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Link RAM: next-slot pointer of every slot.
    mqsb_ram #(
        .WIDTH (PW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Data RAM: stored values.
    mqsb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (val_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    // Queue RAM: {tail, head} of every queue.
    mqsb_ram #(
        .WIDTH (2 * PW),
        .DEPTH (QUEUES)
    ) u_queue_ram (
        .clk   (aclk),
        .we    (qram_we),
        .waddr (qram_waddr),
        .wdata (qram_wdata),
        .re    (qram_re),
        .raddr (qram_raddr),
        .rdata (qram_rdata)
    );

    // An empty free list means every untouched slot has been handed out.
    a_free_empty_fresh_done: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (free_head_reg == NIL) |-> (fresh_cnt_reg == PW'(SLOTS))
    ) else $error("free list empty while untouched slots remain");

    // Overflow is only reported for an enqueue with an empty free list.
    a_overflow_cause: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (out_load && m_tuser_next == STAT_OVERFLOW) |->
            (act_reg == ACT_ENQ && free_head_reg == NIL)
    ) else $error("overflow reported without cause");

    // Underflow is only reported for a dequeue.
    a_underflow_cause: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (out_load && m_tuser_next == STAT_UNDERFLOW) |-> (act_reg == ACT_DEQ)
    ) else $error("underflow reported for an enqueue");

    // A new beat is never taken in the cycle after one was accepted.
    a_no_back_to_back: assert property (
        @(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready
    ) else $error("input accepted while an operation is in progress");

endmodule
`default_nettype wire

### hdl/mqsb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqsb_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
